FILE: hw/rtl/hsip_pkg.sv
// hsip_pkg: constants shared by the half-sine impulse pulse pipeline
// fixed-point pi, cordic gain, arctangent table, register map and pipeline sizing
// no dependencies
package hsip_pkg;

   localparam int SINE_ITERATIONS = 16;

   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
   localparam logic [31:0] SAMPLE_PERIOD_RESET = 32'd97391;

   // register index from the csr byte address (4 bytes per register)
   localparam logic REG_SAMPLE_PERIOD = 1'b0;

   // arctangent of 2^-i in q2.30
   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
      32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
      32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
      32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
   };

   // pipeline stage map
   localparam int STG_SQRT_LAST = 33;                  // sqrt steps at stages 2..33
   localparam int STG_RDIV_LAST = 34;                  // phase divide at stages 2..34
   localparam int STG_ANGLE     = 35;                  // fold and angle multiply
   localparam int STG_DIR_LAST  = 65;                  // direction divide 35..65
   localparam int STG_CORDIC    = 36;
   localparam int STG_PROD      = STG_CORDIC + SINE_ITERATIONS;
   localparam int STG_NUM       = STG_PROD + 1;
   localparam int STG_QSETUP    = STG_PROD + 2;
   localparam int STG_QLAST     = STG_PROD + 34;
   localparam int STG_OUT       = STG_PROD + 35;
   localparam int NUM_STAGES    = STG_OUT + 1;

endpackage

FILE: hw/rtl/half_sine_impulse_pulse.sv
// half_sine_impulse_pulse: streaming half-sine contact pulse generator
// one fully pipelined datapath; uses hsip_pkg for constants and stage map
//
// usage:
//   req channel: one transfer per impulse/sample pair; tdata carries
//   sample_index, start_time, duration, dv_x, dv_y, dv_z from the lowest bit up.
//   rsp channel: one transfer per request; tdata carries pulse_value and the
//   unit direction, tuser carries in_window and zero_impulse.
//   csr port: apb-style, register 0 (byte address 0) is sample_period.
//   the pipeline depth (NUM_STAGES, with 16 sine iterations) is set by the
//   bit-per-stage divides and square root plus the cordic stages.
//   throughput is one transfer per cycle; every stage holds its item while
//   rsp_tready is low and the last stage is full, and req_tready drops with it.
//   reset empties the pipeline and loads sample_period with 97391.
//   write sample_period only while no request is in flight.
module half_sine_impulse_pulse
   import hsip_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sample_index[31:0], start_time[79:32], duration[111:80],
   // dv_x[143:112], dv_y[175:144], dv_z[207:176]
   input  logic [207:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pulse_value[31:0], dir_x[63:32], dir_y[95:64], dir_z[127:96]
   output logic [127:0] rsp_tdata,
   // in_window[0], zero_impulse[1]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef struct packed {
      logic [63:0]        t;
      logic [47:0]        start;
      logic [31:0]        dur;
      logic [2:0]         neg;
      logic [2:0][31:0]   mag;
      logic [2:0][63:0]   sqa;
      logic               inw;
      logic               act;
      logic [31:0]        rrem;
      logic [32:0]        rq;
      logic [63:0]        sop;
      logic [63:0]        sres;
      logic signed [33:0] cx;
      logic signed [33:0] cy;
      logic signed [33:0] cz;
      logic [31:0]        m;
      logic [30:0]        s;
      logic [31:0]        p;
      logic [63:0]        qnum;
      logic [38:0]        qrem;
      logic [31:0]        qlo;
      logic [31:0]        qq;
      logic               sat;
      logic [2:0][31:0]   drem;
      logic [2:0][30:0]   dq;
      logic [31:0]        pulse;
      logic [2:0][31:0]   dir;
      logic               zimp;
   } stage_type;

   logic [31:0] sample_period_ff;
   logic        csr_write;
   logic        en;

   stage_type             st_in [NUM_STAGES];
   stage_type             st_ff [NUM_STAGES];
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] vld_ff;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_SAMPLE_PERIOD) ? sample_period_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff <= SAMPLE_PERIOD_RESET;
      end else if (csr_write && csr_paddr[2] == REG_SAMPLE_PERIOD) begin
         sample_period_ff <= csr_pwdata;
      end
   end

   // global advance: the whole pipeline moves unless the output is held
   assign en         = !vld_ff[NUM_STAGES-1] || rsp_tready;
   assign req_tready = en;
   assign vld_in     = {vld_ff[NUM_STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      localparam int SQ_SH = (k >= 2 && k <= STG_SQRT_LAST) ? 62 - 2 * (k - 2) : 0;
      localparam int RD_J  = (k >= 2) ? k - 2 : 0;
      localparam int DR_J  = (k >= STG_ANGLE) ? k - STG_ANGLE : 0;
      localparam int CI    = (k >= STG_CORDIC && k < STG_PROD) ? k - STG_CORDIC : 0;

      if (k == 0) begin : g_entry
         always_comb begin
            logic [31:0] dv;
            st_in[0]       = '0;
            st_in[0].t     = 64'(req_tdata[31:0]) * 64'(sample_period_ff);
            st_in[0].start = req_tdata[79:32];
            st_in[0].dur   = req_tdata[111:80];
            for (int c = 0; c < 3; c++) begin
               dv = req_tdata[112 + 32 * c +: 32];
               st_in[0].neg[c] = dv[31];
               st_in[0].mag[c] = dv[31] ? (~dv + 32'd1) : dv;
               st_in[0].sqa[c] = 64'(st_in[0].mag[c]) * 64'(st_in[0].mag[c]);
            end
         end
      end else begin : g_step
         always_comb begin
            logic [63:0]        diff;
            logic [64:0]        ssum;
            logic [32:0]        rem2;
            logic [32:0]        rfold;
            logic [63:0]        prod;
            logic signed [33:0] xs;
            logic signed [33:0] ys;
            logic signed [33:0] at;
            logic [38:0]        den;
            logic [39:0]        qr2;
            logic               b;
            st_in[k] = st_ff[k-1];

            if (k == 1) begin
               st_in[k].sop  = st_ff[k-1].sqa[0] + st_ff[k-1].sqa[1] + st_ff[k-1].sqa[2];
               diff          = st_ff[k-1].t - {16'd0, st_ff[k-1].start};
               st_in[k].inw  = (st_ff[k-1].t >= {16'd0, st_ff[k-1].start}) &&
                               (diff <= {32'd0, st_ff[k-1].dur});
               st_in[k].act  = st_in[k].inw && (st_ff[k-1].dur != 32'd0);
               st_in[k].rrem = diff[31:0];
               st_in[k].rq   = '0;
               st_in[k].sres = '0;
            end

            // square root, one result bit per stage
            if (k >= 2 && k <= STG_SQRT_LAST) begin
               ssum = {1'b0, st_in[k].sres} + (65'd1 << SQ_SH);
               if ({1'b0, st_in[k].sop} >= ssum) begin
                  st_in[k].sop  = st_in[k].sop - ssum[63:0];
                  st_in[k].sres = (st_in[k].sres >> 1) + (64'd1 << SQ_SH);
               end else begin
                  st_in[k].sres = st_in[k].sres >> 1;
               end
            end

            // phase divide (t - start) * 2^32 / duration, one bit per stage
            if (k >= 2 && k <= STG_RDIV_LAST) begin
               rem2 = (RD_J == 0) ? {1'b0, st_in[k].rrem} : {st_in[k].rrem, 1'b0};
               b    = rem2 >= {1'b0, st_in[k].dur};
               if (b) begin
                  rem2 = rem2 - {1'b0, st_in[k].dur};
               end
               st_in[k].rrem = rem2[31:0];
               st_in[k].rq   = {st_in[k].rq[31:0], b};
            end

            if (k == STG_ANGLE) begin
               rfold = st_in[k].rq;
               if (rfold > 33'h080000000) begin
                  rfold = 33'h100000000 - rfold;
               end
               prod        = 64'(rfold[31:0]) * 64'(PI_Q30);
               st_in[k].cz = $signed({2'b00, prod[63:32]});
               st_in[k].cx = CORDIC_K;
               st_in[k].cy = '0;
               st_in[k].m  = st_in[k].sres[31:0];
               for (int c = 0; c < 3; c++) begin
                  st_in[k].drem[c] = st_in[k].mag[c];
                  st_in[k].dq[c]   = '0;
               end
            end

            // direction divide |dv_c| * 2^30 / m, three lanes
            if (k >= STG_ANGLE && k <= STG_DIR_LAST) begin
               for (int c = 0; c < 3; c++) begin
                  rem2 = (DR_J == 0) ? {1'b0, st_in[k].drem[c]} : {st_in[k].drem[c], 1'b0};
                  b    = rem2 >= {1'b0, st_in[k].m};
                  if (b) begin
                     rem2 = rem2 - {1'b0, st_in[k].m};
                  end
                  st_in[k].drem[c] = rem2[31:0];
                  st_in[k].dq[c]   = {st_in[k].dq[c][29:0], b};
               end
            end

            if (k >= STG_CORDIC && k < STG_PROD) begin
               xs = st_in[k].cx >>> CI;
               ys = st_in[k].cy >>> CI;
               at = $signed({2'b00, ATAN_Q30[5'(CI)]});
               if (st_in[k].cz >= 0) begin
                  st_in[k].cx = st_in[k].cx - ys;
                  st_in[k].cy = st_in[k].cy + xs;
                  st_in[k].cz = st_in[k].cz - at;
               end else begin
                  st_in[k].cx = st_in[k].cx + ys;
                  st_in[k].cy = st_in[k].cy - xs;
                  st_in[k].cz = st_in[k].cz + at;
               end
            end

            if (k == STG_PROD) begin
               priority if (st_in[k].cy < 0) begin
                  st_in[k].s = '0;
               end else if (st_in[k].cy > 34'sd1073741824) begin
                  st_in[k].s = 31'h40000000;
               end else begin
                  st_in[k].s = st_in[k].cy[30:0];
               end
               prod       = 64'(st_in[k].m) * 64'(st_in[k].s);
               st_in[k].p = prod[61:30];
            end

            if (k == STG_NUM) begin
               st_in[k].qnum = 64'(st_in[k].p) * 64'(PI_Q30);
            end

            den = {st_in[k].dur, 7'd0};

            if (k == STG_QSETUP) begin
               st_in[k].sat  = {7'd0, st_in[k].qnum[63:32]} >= den;
               st_in[k].qrem = {7'd0, st_in[k].qnum[63:32]};
               st_in[k].qlo  = st_in[k].qnum[31:0];
               st_in[k].qq   = '0;
            end

            // pulse divide by duration * 2^7, one bit per stage
            if (k > STG_QSETUP && k <= STG_QLAST) begin
               qr2 = {st_in[k].qrem, st_in[k].qlo[31]};
               b   = qr2 >= {1'b0, den};
               if (b) begin
                  qr2 = qr2 - {1'b0, den};
               end
               st_in[k].qrem = qr2[38:0];
               st_in[k].qlo  = {st_in[k].qlo[30:0], 1'b0};
               st_in[k].qq   = {st_in[k].qq[30:0], b};
            end

            if (k == STG_OUT) begin
               st_in[k].zimp  = st_in[k].m == 32'd0;
               st_in[k].pulse = (st_in[k].act && !st_in[k].zimp) ?
                                (st_in[k].sat ? 32'hFFFFFFFF : st_in[k].qq) : 32'd0;
               for (int c = 0; c < 3; c++) begin
                  if (st_in[k].zimp) begin
                     st_in[k].dir[c] = '0;
                  end else if (st_in[k].neg[c]) begin
                     st_in[k].dir[c] = 32'd0 - {1'b0, st_in[k].dq[c]};
                  end else begin
                     st_in[k].dir[c] = {1'b0, st_in[k].dq[c]};
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign rsp_tvalid = vld_ff[NUM_STAGES-1];
   assign rsp_tdata  = {st_ff[NUM_STAGES-1].dir[2], st_ff[NUM_STAGES-1].dir[1],
                        st_ff[NUM_STAGES-1].dir[0], st_ff[NUM_STAGES-1].pulse};
   assign rsp_tuser  = {st_ff[NUM_STAGES-1].zimp, st_ff[NUM_STAGES-1].inw};

endmodule

FILE: sim/half_sine_impulse_pulse_tb.sv
// half_sine_impulse_pulse_tb: self-checking bench for the half-sine impulse pulse pipeline
// predicts each response from the request and sample_period; depends on hsip_pkg and the rtl
`timescale 1ns / 1ps

module half_sine_impulse_pulse_tb
   import hsip_pkg::*;
();

   typedef struct packed {
      logic [31:0] dv_z;
      logic [31:0] dv_y;
      logic [31:0] dv_x;
      logic [31:0] duration;
      logic [47:0] start_time;
      logic [31:0] sample_index;
   } pulse_req_type;

   typedef struct {
      logic [31:0] pulse_value;
      logic        in_window;
      logic [31:0] dir_x;
      logic [31:0] dir_y;
      logic [31:0] dir_z;
      logic        zero_impulse;
   } pulse_rsp_type;

   localparam int LATENCY = NUM_STAGES;
   localparam int IDLE_LIMIT = 20000;

   int errors = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // arithmetic shift right with floor
   function automatic longint shr_floor(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] op, res, one;
      op = v;
      res = 0;
      one = 64'd1 << 62;
      while (one > op) one >>= 2;
      while (one != 0) begin
         if (op >= res + one) begin
            op -= res + one;
            res = (res >> 1) + one;
         end else begin
            res >>= 1;
         end
         one >>= 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] half_sine(input longint z_in);
      longint x, y, z, xs, ys;
      z = z_in;
      x = CORDIC_K;
      y = 0;
      for (int i = 0; i < SINE_ITERATIONS && i < 32; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
         end else begin
            x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
         end
      end
      if (y < 0) y = 0;
      if (y > (64'sd1 <<< 30)) y = 64'sd1 <<< 30;
      return y;
   endfunction

   class pulse_scoreboard;
      logic [31:0]   period;
      pulse_rsp_type pending[$];

      function new();
         period = SAMPLE_PERIOD_RESET;
      endfunction

      function void note_request(input pulse_req_type rq);
         pulse_rsp_type e;
         longint dv[3];
         logic [63:0] mag[3], sq, m, t, wend, r, s, p;
         logic [127:0] q, num;
         logic [63:0] d;
         logic inw;
         dv[0] = $signed(rq.dv_x);
         dv[1] = $signed(rq.dv_y);
         dv[2] = $signed(rq.dv_z);
         sq = 0;
         for (int c = 0; c < 3; c++) begin
            mag[c] = dv[c] < 0 ? -dv[c] : dv[c];
            sq += mag[c] * mag[c];
         end
         m = root_floor(sq);
         t = 64'(rq.sample_index) * 64'(period);
         wend = 64'(rq.start_time) + 64'(rq.duration);
         inw = (t >= 64'(rq.start_time)) && (t <= wend);
         e.pulse_value = 0;
         if (inw && rq.duration != 0 && m != 0) begin
            r = ((t - 64'(rq.start_time)) << 32) / 64'(rq.duration);
            if (r > (64'd1 << 31)) r = (64'd1 << 32) - r;
            s = half_sine(longint'((r * 64'(PI_Q30)) >> 32));
            p = (m * s) >> 30;
            num = 128'(p) * 128'(PI_Q30);
            q = num / (128'(rq.duration) << 7);
            e.pulse_value = q > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
         end
         e.in_window = inw;
         for (int c = 0; c < 3; c++) begin
            d = 0;
            if (m != 0) begin
               d = (mag[c] << 30) / m;
               if (dv[c] < 0) d = 0 - d;
            end
            if (c == 0) e.dir_x = d[31:0];
            else if (c == 1) e.dir_y = d[31:0];
            else e.dir_z = d[31:0];
         end
         e.zero_impulse = (m == 0);
         pending.insert(pending.size(), e);
      endfunction

      task check_response(input logic [127:0] data, input logic [1:0] user);
         pulse_rsp_type e;
         if (pending.size() == 0) begin
            report("unexpected transfer", data[63:0], 0);
            return;
         end
         e = pending.pop_front();
         if (data[31:0] !== e.pulse_value) report("pulse_value", data[31:0], e.pulse_value);
         if (data[63:32] !== e.dir_x) report("dir_x", data[63:32], e.dir_x);
         if (data[95:64] !== e.dir_y) report("dir_y", data[95:64], e.dir_y);
         if (data[127:96] !== e.dir_z) report("dir_z", data[127:96], e.dir_z);
         if (user[0] !== e.in_window) report("in_window", user[0], e.in_window);
         if (user[1] !== e.zero_impulse) report("zero_impulse", user[1], e.zero_impulse);
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [207:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   half_sine_impulse_pulse dut (.*);

   pulse_scoreboard board = new();
   bit calm = 0;          // no idling in the last part
   bit hold_rsp = 0;      // long receiver stall
   int idle_cycles = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_request(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random stall bursts unless calm, or a held stretch
   initial begin
      int n;
      rsp_tready <= 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            @(posedge clock);
         end else if (!calm && $urandom_range(3) == 0) begin
            n = $urandom_range(16, 1);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(20, 1);
            rsp_tready <= 1;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_request(input pulse_req_type rq);
      int gap;
      if (!calm && $urandom_range(4) == 0) begin
         gap = $urandom_range(16, 1);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= rq;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_period(input logic [31:0] value);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= 3'(REG_SAMPLE_PERIOD) << 2; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      board.period = value;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_dv();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 0;
         3: return $urandom_range(2048) - 1024;
         default: return $urandom;
      endcase
   endfunction

   // mostly in-window samples with random content, some far off
   function automatic pulse_req_type rand_request(input logic [31:0] period);
      pulse_req_type rq;
      logic [63:0] t;
      rq.sample_index = $urandom_range(3) == 0 ? $urandom : $urandom_range(65535);
      rq.duration = $urandom_range(7) == 0 ? $urandom : $urandom_range(32'h0400_0000, 1);
      rq.dv_x = rand_dv(); rq.dv_y = rand_dv(); rq.dv_z = rand_dv();
      t = 64'(rq.sample_index) * 64'(period);
      case ($urandom_range(9))
         0: rq.start_time = {16'($urandom_range(65535)), $urandom};
         1: rq.start_time = t[47:0] + 48'd1;
         2: rq.start_time = t[47:0] - 48'(rq.duration);
         default: rq.start_time = t[47:0] - 48'($urandom_range(rq.duration));
      endcase
      if (t[63:48] != 0) rq.start_time = {16'($urandom_range(65535)), $urandom};
      return rq;
   endfunction

   initial begin
      pulse_req_type rq;
      logic [31:0] periods[5];
      reset <= 1;
      req_tvalid <= 0;
      req_tdata <= 0;
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0; csr_paddr <= 0; csr_pwdata <= 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, window edges, zero impulse, saturation
      rq = '{dv_z: 0, dv_y: 0, dv_x: 0, duration: 1, start_time: 0, sample_index: 0};
      send_request(rq);
      rq = '{dv_z: 32'h8000_0000, dv_y: 32'h8000_0000, dv_x: 32'h8000_0000,
             duration: 1, start_time: 48'd97391, sample_index: 1};
      send_request(rq);
      rq = '{dv_z: 32'h7FFF_FFFF, dv_y: 32'h7FFF_FFFF, dv_x: 32'h7FFF_FFFF,
             duration: 32'hFFFF_FFFF, start_time: 0, sample_index: 32'hFFFF_FFFF};
      send_request(rq);
      rq = '{dv_z: 0, dv_y: 0, dv_x: 32'h0100_0000, duration: 200000,
             start_time: 0, sample_index: 1};
      send_request(rq);
      rq.start_time = 48'hFFFF_FFFF_FFFF; send_request(rq);
      rq.start_time = 48'(97391 - 200000 + 97391); rq.sample_index = 1; send_request(rq);
      rq.start_time = 0; rq.duration = 97390; send_request(rq);
      rq.duration = 97391; send_request(rq);
      rq.dv_x = 32'h7FFF_FFFF; rq.duration = 194782; send_request(rq);
      rq.dv_y = 32'hFFFF_FFFF; rq.dv_z = 32'h0000_0001; send_request(rq);
      drain();

      // zero period: every sample lands at time zero
      write_period(0);
      rq = '{dv_z: 5, dv_y: -7, dv_x: 3, duration: 1, start_time: 0,
             sample_index: 32'hFFFF_FFFF};
      send_request(rq);
      rq.start_time = 1; send_request(rq);
      drain();

      periods = '{32'hFFFF_FFFF, 1, 97391, 32'h0001_0000, 0};
      periods[4] = $urandom;
      for (int ph = 0; ph < 5; ph++) begin
         write_period(periods[ph]);
         for (int k = 0; k < 260; k++) begin
            if (ph == 2 && k == 50) fork
               begin
                  hold_rsp = 1;
                  repeat (400) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
            if (ph == 4 && k == 160) calm = 1;
            send_request(rand_request(periods[ph]));
         end
         drain();
      end

      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/hsip_pkg.sv
hw/rtl/half_sine_impulse_pulse.sv
sim/half_sine_impulse_pulse_tb.sv
